// ----- hw/rtl/kps_pkg.sv -----
package kps_pkg;

  localparam int STATE_DIM  = 4;
  localparam int COMPONENTS = 2;
  localparam int IDX_W      = 2;
  localparam int COMP_W     = 1;
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = 72;

  localparam logic [2:0] OP_LOAD_F   = 3'd0;
  localparam logic [2:0] OP_LOAD_Q   = 3'd1;
  localparam logic [2:0] OP_LOAD_X   = 3'd2;
  localparam logic [2:0] OP_LOAD_P   = 3'd3;
  localparam logic [2:0] OP_RUN      = 3'd4;

  typedef logic signed [DATA_W-1:0] word_t;

  // One slot of the MAC chain: running sum plus the operand pairs still to go.
  typedef struct packed {
    logic                                vld;
    logic signed [ACC_W-1:0]             acc;
    logic [STATE_DIM-1:0][DATA_W-1:0]    a;
    logic [STATE_DIM-1:0][DATA_W-1:0]    b;
  } mac_bus_t;

endpackage

// ----- hw/rtl/kps_mac_cell.sv -----
module kps_mac_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  kps_pkg::mac_bus_t in_bus,
  output kps_pkg::mac_bus_t out_bus
);
  import kps_pkg::*;

  logic signed [2*DATA_W-1:0] prod;
  mac_bus_t                   bus_nxt;
  mac_bus_t                   bus_r;

  // consume pair 0, shift the rest down for the next cell
  always_comb begin
    prod = $signed(in_bus.a[0]) * $signed(in_bus.b[0]);
    bus_nxt.vld = in_bus.vld;
    bus_nxt.acc = in_bus.acc + {{(ACC_W-2*DATA_W){prod[2*DATA_W-1]}}, prod};
    for (int k = 0; k < STATE_DIM-1; k++) begin
      bus_nxt.a[k] = in_bus.a[k+1];
      bus_nxt.b[k] = in_bus.b[k+1];
    end
    bus_nxt.a[STATE_DIM-1] = '0;
    bus_nxt.b[STATE_DIM-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.vld <= 1'b0;
    end else begin
      bus_r <= bus_nxt;
    end
  end

  assign out_bus = bus_r;

endmodule

// ----- hw/rtl/kalman_predict_step_core.sv -----
// Kalman prediction for a two-component Gaussian mixture, 4-state, signed Q16.16.
// Load items (F, Q, per-component mean x and covariance P) write one element each and
// produce nothing. A run item produces, per component, 4 mean elements F*x followed
// by 16 covariance elements F*P*F'+Q in row-major order; out_last marks the final
// one. With skip_state set, x and P are passed through unchanged. Every dot product
// goes through a chain of STATE_DIM multiply-accumulate cells (one pair per cell)
// and a saturation register, one dot product in flight at a time. Each dot product
// passes through issue, launch register, 4 cells, saturation and put, and a run
// computes 2*(4+16+16) = 72 dot products, or 2*20 = 40 with skip_state; an output
// stall holds a mean or covariance put. No input item is taken during a run.
// Sums are exact; the result is shifted right arithmetically by 16 and saturated.
module kalman_predict_step_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_operation,
  input  logic [0:0]                in_component,
  input  logic [1:0]                in_row,
  input  logic [1:0]                in_col,
  input  logic signed [31:0]        in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_kind,
  output logic [0:0]                out_component,
  output logic [1:0]                out_row,
  output logic [1:0]                out_col,
  output logic signed [31:0]        out_value,
  output logic                      out_last
);
  import kps_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_PUT} state_t;
  typedef enum logic [1:0] {PH_MEAN, PH_FP, PH_COV} phase_t;

  state_t              state_r;
  phase_t              phase_r;
  logic [COMP_W-1:0]   comp_r;
  logic [IDX_W-1:0]    i_r, j_r;
  logic                skip_r;

  // element stores; F, Q, x and P are written only by loads, tmp only by F*P puts; unwritten entries are don't-care
  word_t f_r   [STATE_DIM*STATE_DIM];
  word_t q_r   [STATE_DIM*STATE_DIM];
  word_t x_r   [COMPONENTS*STATE_DIM];
  word_t p_r   [COMPONENTS*STATE_DIM*STATE_DIM];
  word_t tmp_r [STATE_DIM*STATE_DIM];   // F*P, saturated

  mac_bus_t launch_r, launch_nxt;
  mac_bus_t bus [STATE_DIM+1];

  logic                    sat_vld_r;
  word_t                   sat_r;
  logic signed [ACC_W-FRAC_W-1:0] shifted;
  word_t                   sat_nxt;

  logic in_acc, out_free, out_load, is_last, at_end_i, at_end_j;
  word_t init_w;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = (state_r == S_PUT) && (phase_r != PH_FP) && out_free;
  assign at_end_i = (i_r == IDX_W'(STATE_DIM-1));
  assign at_end_j = (j_r == IDX_W'(STATE_DIM-1));
  assign is_last  = (phase_r == PH_COV) && at_end_i && at_end_j &&
                    (comp_r == COMP_W'(COMPONENTS-1));

  // operands for the next dot product
  always_comb begin
    init_w = '0;
    launch_nxt.vld = (state_r == S_ISSUE);
    for (int k = 0; k < STATE_DIM; k++) begin
      launch_nxt.a[k] = '0;
      launch_nxt.b[k] = '0;
    end
    case (phase_r)
      PH_MEAN: begin
        for (int k = 0; k < STATE_DIM; k++) begin
          launch_nxt.a[k] = skip_r ? '0 : f_r[{i_r, IDX_W'(k)}];
          launch_nxt.b[k] = x_r[{comp_r, IDX_W'(k)}];
        end
        init_w = skip_r ? x_r[{comp_r, i_r}] : '0;
      end
      PH_FP: begin
        for (int k = 0; k < STATE_DIM; k++) begin
          launch_nxt.a[k] = f_r[{i_r, IDX_W'(k)}];
          launch_nxt.b[k] = p_r[{comp_r, IDX_W'(k), j_r}];
        end
      end
      PH_COV: begin
        for (int k = 0; k < STATE_DIM; k++) begin
          launch_nxt.a[k] = skip_r ? '0 : tmp_r[{i_r, IDX_W'(k)}];
          launch_nxt.b[k] = skip_r ? '0 : f_r[{j_r, IDX_W'(k)}];
        end
        init_w = skip_r ? p_r[{comp_r, i_r, j_r}] : q_r[{i_r, j_r}];
      end
      default: ;
    endcase
    // value times 2^16 so that the final shift gives it back
    launch_nxt.acc = {{(ACC_W-DATA_W-FRAC_W){init_w[DATA_W-1]}}, init_w, {FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r.vld <= 1'b0;
    end else begin
      launch_r <= launch_nxt;
    end
  end

  assign bus[0] = launch_r;

  for (genvar g = 0; g < STATE_DIM; g++) begin : g_cell
    kps_mac_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_bus  (bus[g]),
      .out_bus (bus[g+1])
    );
  end

  // shift and saturate
  always_comb begin
    shifted = bus[STATE_DIM].acc[ACC_W-1:FRAC_W];
    if (shifted[ACC_W-FRAC_W-1:DATA_W-1] == '0 ||
        shifted[ACC_W-FRAC_W-1:DATA_W-1] == '1) begin
      sat_nxt = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-FRAC_W-1]) begin
      sat_nxt = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_nxt = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // sat_r holds its result while the put waits on the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_vld_r <= 1'b0;
    end else begin
      sat_vld_r <= bus[STATE_DIM].vld;
    end
    if (bus[STATE_DIM].vld) begin
      sat_r <= sat_nxt;
    end
  end

  // element stores
  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (in_operation)
        OP_LOAD_F: f_r[{in_row, in_col}] <= in_value;
        OP_LOAD_Q: q_r[{in_row, in_col}] <= in_value;
        OP_LOAD_X: x_r[{in_component, in_row}] <= in_value;
        OP_LOAD_P: p_r[{in_component, in_row, in_col}] <= in_value;
        default: ;
      endcase
    end
    if (state_r == S_PUT && phase_r == PH_FP) begin
      tmp_r[{i_r, j_r}] <= sat_r;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_MEAN;
      comp_r    <= '0;
      i_r       <= '0;
      j_r       <= '0;
      skip_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        skip_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_operation == OP_RUN) begin
            phase_r <= PH_MEAN;
            comp_r  <= '0;
            i_r     <= '0;
            j_r     <= '0;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: state_r <= S_WAIT;
        S_WAIT: begin
          if (sat_vld_r) begin
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          if (phase_r == PH_FP || out_free) begin
            if (phase_r != PH_FP) begin
              out_kind      <= (phase_r == PH_COV);
              out_component <= comp_r;
              out_row       <= i_r;
              out_col       <= (phase_r == PH_COV) ? j_r : '0;
              out_value     <= sat_r;
              out_last      <= is_last;
            end
            state_r <= S_ISSUE;
            if (phase_r == PH_MEAN) begin
              if (at_end_i) begin
                i_r     <= '0;
                j_r     <= '0;
                phase_r <= skip_r ? PH_COV : PH_FP;
              end else begin
                i_r <= i_r + 1'b1;
              end
            end else if (!at_end_j) begin
              j_r <= j_r + 1'b1;
            end else begin
              j_r <= '0;
              if (!at_end_i) begin
                i_r <= i_r + 1'b1;
              end else begin
                i_r <= '0;
                if (phase_r == PH_FP) begin
                  phase_r <= PH_COV;
                end else if (is_last) begin
                  state_r <= S_IDLE;
                end else begin
                  comp_r  <= comp_r + 1'b1;
                  phase_r <= PH_MEAN;
                end
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
